// ===== hdl/ssep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event stream parser package
// Shared types, codes, constants, prefix tables and message table of the event stream parser.
// ----------------------------------------------------------------------------
package ssep_pkg;

    localparam int TYPE_MAX_DEF = 32;
    localparam int LINE_W = 24;
    localparam logic [LINE_W-1:0] MAX_LINE_RESET = 24'd10485760;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_E = 8'h65;
    localparam logic [7:0] CH_D = 8'h64;

    localparam logic [2:0] EVENT_PREFIX_LAST = 3'd6;
    localparam logic [2:0] DATA_PREFIX_LAST = 3'd5;
    localparam logic [2:0] MESSAGE_LEN = 3'd7;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_TYPE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef enum logic [2:0] {
        OP_DATA     = 3'd0,
        OP_STORE    = 3'd1,
        OP_CLRTYPE  = 3'd2,
        OP_DISPATCH = 3'd3,
        OP_ERROR    = 3'd4
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       two;
        logic       emit;
        logic [7:0] data;
    } t_cmd;

    function automatic logic [7:0] event_prefix_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0: c = 8'h65;
            3'd1: c = 8'h76;
            3'd2: c = 8'h65;
            3'd3: c = 8'h6E;
            3'd4: c = 8'h74;
            3'd5: c = 8'h3A;
            3'd6: c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] data_prefix_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0: c = 8'h64;
            3'd1: c = 8'h61;
            3'd2: c = 8'h74;
            3'd3: c = 8'h61;
            3'd4: c = 8'h3A;
            3'd5: c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] message_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0: c = 8'h6D;
            3'd1: c = 8'h65;
            3'd2: c = 8'h73;
            3'd3: c = 8'h73;
            3'd4: c = 8'h61;
            3'd5: c = 8'h67;
            3'd6: c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ssep_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event stream parser front end
// Tracks the line state of each accepted byte and issues commands to the back end.
// ----------------------------------------------------------------------------
module ssep_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic [7:0]                  i_byte,
    input  wire logic [ssep_pkg::LINE_W-1:0] i_max_len,
    output logic                             o_push,
    output ssep_pkg::t_cmd                   o_cmd
);

    typedef enum logic [5:0] {
        MODE_START     = 6'b000001,
        MODE_PRE_EVENT = 6'b000010,
        MODE_PRE_DATA  = 6'b000100,
        MODE_EVENT     = 6'b001000,
        MODE_DATA      = 6'b010000,
        MODE_IGNORE    = 6'b100000
    } t_mode;

    t_mode                       r_mode, n_mode, mode_eff;
    logic [2:0]                  r_pos, n_pos;
    logic [ssep_pkg::LINE_W-1:0] r_len, n_len;
    logic                        r_crp, n_crp;
    logic                        r_dne, n_dne;
    logic                        r_halted, n_halted;
    logic                        cr_content, b_content;

    always_comb begin
        n_mode = r_mode;
        n_pos = r_pos;
        n_len = r_len;
        n_crp = r_crp;
        n_dne = r_dne;
        n_halted = r_halted;
        mode_eff = r_mode;
        cr_content = 1'b0;
        b_content = 1'b0;
        o_push = 1'b0;
        o_cmd.op = ssep_pkg::OP_DATA;
        o_cmd.two = 1'b0;
        o_cmd.emit = 1'b0;
        o_cmd.data = i_byte;
        if (i_accept && !r_halted) begin
            if (({1'b0, r_len} + 25'd1) > {1'b0, i_max_len}) begin
                n_halted = 1'b1;
                o_push = 1'b1;
                o_cmd.op = ssep_pkg::OP_ERROR;
                o_cmd.data = 8'd0;
            end else begin
                n_len = r_len + 24'd1;
                if (i_byte == ssep_pkg::CH_LF) begin
                    if (r_mode == MODE_START) begin
                        o_push = 1'b1;
                        o_cmd.op = ssep_pkg::OP_DISPATCH;
                        o_cmd.emit = r_dne;
                        n_dne = 1'b0;
                    end
                    n_mode = MODE_START;
                    n_pos = 3'd0;
                    n_len = '0;
                    n_crp = 1'b0;
                end else begin
                    if (r_crp) begin
                        n_crp = 1'b0;
                        if (r_mode == MODE_START) begin
                            mode_eff = MODE_IGNORE;
                            n_mode = MODE_IGNORE;
                        end else begin
                            cr_content = 1'b1;
                        end
                    end
                    case (mode_eff)
                        MODE_START: begin
                            if (i_byte == ssep_pkg::CH_E) begin
                                n_mode = MODE_PRE_EVENT;
                                n_pos = 3'd1;
                            end else if (i_byte == ssep_pkg::CH_D) begin
                                n_mode = MODE_PRE_DATA;
                                n_pos = 3'd1;
                            end else if (i_byte == ssep_pkg::CH_CR) begin
                                n_crp = 1'b1;
                            end else begin
                                n_mode = MODE_IGNORE;
                            end
                        end
                        MODE_PRE_EVENT: begin
                            if (i_byte == ssep_pkg::event_prefix_char(r_pos)) begin
                                n_pos = r_pos + 3'd1;
                                if (r_pos == ssep_pkg::EVENT_PREFIX_LAST) begin
                                    n_mode = MODE_EVENT;
                                    o_push = 1'b1;
                                    o_cmd.op = ssep_pkg::OP_CLRTYPE;
                                end
                            end else begin
                                n_mode = MODE_IGNORE;
                            end
                        end
                        MODE_PRE_DATA: begin
                            if (i_byte == ssep_pkg::data_prefix_char(r_pos)) begin
                                n_pos = r_pos + 3'd1;
                                if (r_pos == ssep_pkg::DATA_PREFIX_LAST) begin
                                    n_mode = MODE_DATA;
                                    if (r_dne) begin
                                        o_push = 1'b1;
                                        o_cmd.op = ssep_pkg::OP_DATA;
                                        o_cmd.data = ssep_pkg::CH_LF;
                                    end
                                end
                            end else begin
                                n_mode = MODE_IGNORE;
                            end
                        end
                        MODE_DATA, MODE_EVENT: begin
                            if (i_byte == ssep_pkg::CH_CR) begin
                                n_crp = 1'b1;
                            end else begin
                                b_content = 1'b1;
                            end
                        end
                        default: begin
                            n_mode = MODE_IGNORE;
                        end
                    endcase
                    if (cr_content || b_content) begin
                        o_push = 1'b1;
                        o_cmd.op = (mode_eff == MODE_DATA) ? ssep_pkg::OP_DATA
                                                           : ssep_pkg::OP_STORE;
                        o_cmd.two = cr_content && b_content;
                        o_cmd.data = b_content ? i_byte : ssep_pkg::CH_CR;
                        if (mode_eff == MODE_DATA) begin
                            n_dne = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_START;
            r_pos <= 3'd0;
            r_len <= '0;
            r_crp <= 1'b0;
            r_dne <= 1'b0;
            r_halted <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_pos <= n_pos;
            r_len <= n_len;
            r_crp <= n_crp;
            r_dne <= n_dne;
            r_halted <= n_halted;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ssep_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event stream parser command queue
// Short first-in first-out queue of commands between the front and back ends.
// ----------------------------------------------------------------------------
module ssep_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ssep_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output ssep_pkg::t_cmd      o_head
);

    ssep_pkg::t_cmd                r_entries [ssep_pkg::QUEUE_DEPTH];
    logic [ssep_pkg::QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [ssep_pkg::QUEUE_AW:0]   r_count;

    assign o_full = (r_count == (ssep_pkg::QUEUE_AW + 1)'(ssep_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head = r_entries[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10: r_count <= r_count + 1'b1;
                2'b01: r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ssep_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event stream parser back end
// Carries out queued commands: data words, type store writes and clears, dispatch, error.
// ----------------------------------------------------------------------------
module ssep_back #(
    parameter int TYPE_MAX = ssep_pkg::TYPE_MAX_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire ssep_pkg::t_cmd i_head,
    output logic                o_pop,
    input  wire logic           i_out_stall,
    output logic                o_out_valid,
    output logic [1:0]          o_out_kind,
    output logic [7:0]          o_out_byte,
    output logic                o_event_end,
    output logic                o_out_last
);

    localparam int CNT_W = ($clog2(TYPE_MAX + 1) > 3) ? $clog2(TYPE_MAX + 1) : 3;
    localparam int ADDR_W = (TYPE_MAX > 1) ? $clog2(TYPE_MAX) : 1;

    typedef enum logic [3:0] {
        ST_CMD    = 4'b0001,
        ST_SECOND = 4'b0010,
        ST_FETCH  = 4'b0100,
        ST_TYPE   = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_type_len, n_type_len;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  idx_inc;
    logic              r_msg, n_msg;
    logic              r_sec_data, n_sec_data;
    logic [7:0]        r_sec_byte, n_sec_byte;

    logic [7:0]        r_mem [TYPE_MAX];
    logic [7:0]        r_rd;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [7:0]        wr_data;

    logic              r_ov;
    logic [1:0]        r_kind;
    logic [7:0]        r_byte;
    logic              r_end, r_last;
    logic              can_load, ld, ld_end, ld_last;
    logic [1:0]        ld_kind;
    logic [7:0]        ld_byte;
    logic              type_room;

    assign can_load = !r_ov || !i_out_stall;
    assign idx_inc = r_idx + 1'b1;
    assign type_room = (r_type_len < CNT_W'(TYPE_MAX));
    assign wr_addr = r_type_len[ADDR_W-1:0];

    always_comb begin
        n_state = r_state;
        n_type_len = r_type_len;
        n_cnt = r_cnt;
        n_idx = r_idx;
        n_msg = r_msg;
        n_sec_data = r_sec_data;
        n_sec_byte = r_sec_byte;
        o_pop = 1'b0;
        ld = 1'b0;
        ld_kind = ssep_pkg::KIND_DATA;
        ld_byte = i_head.data;
        ld_end = 1'b0;
        ld_last = 1'b1;
        wr_en = 1'b0;
        wr_data = i_head.data;
        rd_en = 1'b0;
        rd_addr = '0;
        case (r_state)
            ST_CMD: begin
                if (!i_empty) begin
                    case (i_head.op)
                        ssep_pkg::OP_DATA: begin
                            if (can_load) begin
                                o_pop = 1'b1;
                                ld = 1'b1;
                                if (i_head.two) begin
                                    ld_byte = ssep_pkg::CH_CR;
                                    ld_last = 1'b0;
                                    n_sec_data = 1'b1;
                                    n_sec_byte = i_head.data;
                                    n_state = ST_SECOND;
                                end
                            end
                        end
                        ssep_pkg::OP_STORE: begin
                            o_pop = 1'b1;
                            wr_data = i_head.two ? ssep_pkg::CH_CR : i_head.data;
                            if (type_room) begin
                                wr_en = 1'b1;
                                n_type_len = r_type_len + 1'b1;
                            end
                            if (i_head.two) begin
                                n_sec_data = 1'b0;
                                n_sec_byte = i_head.data;
                                n_state = ST_SECOND;
                            end
                        end
                        ssep_pkg::OP_CLRTYPE: begin
                            o_pop = 1'b1;
                            n_type_len = '0;
                        end
                        ssep_pkg::OP_DISPATCH: begin
                            o_pop = 1'b1;
                            n_type_len = '0;
                            if (i_head.emit) begin
                                n_msg = (r_type_len == '0);
                                n_cnt = (r_type_len == '0) ? CNT_W'(ssep_pkg::MESSAGE_LEN)
                                                           : r_type_len;
                                n_idx = '0;
                                n_state = ST_FETCH;
                            end
                        end
                        ssep_pkg::OP_ERROR: begin
                            if (can_load) begin
                                o_pop = 1'b1;
                                ld = 1'b1;
                                ld_kind = ssep_pkg::KIND_ERROR;
                                ld_byte = 8'd0;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SECOND: begin
                if (r_sec_data) begin
                    if (can_load) begin
                        ld = 1'b1;
                        ld_byte = r_sec_byte;
                        n_state = ST_CMD;
                    end
                end else begin
                    wr_data = r_sec_byte;
                    if (type_room) begin
                        wr_en = 1'b1;
                        n_type_len = r_type_len + 1'b1;
                    end
                    n_state = ST_CMD;
                end
            end
            ST_FETCH: begin
                rd_en = 1'b1;
                rd_addr = r_idx[ADDR_W-1:0];
                n_state = ST_TYPE;
            end
            ST_TYPE: begin
                if (can_load) begin
                    ld = 1'b1;
                    ld_kind = ssep_pkg::KIND_TYPE;
                    ld_byte = r_msg ? ssep_pkg::message_char(r_idx[2:0]) : r_rd;
                    ld_end = (idx_inc == r_cnt);
                    ld_last = ld_end;
                    if (idx_inc == r_cnt) begin
                        n_state = ST_CMD;
                    end else begin
                        n_idx = idx_inc;
                        rd_en = 1'b1;
                        rd_addr = idx_inc[ADDR_W-1:0];
                    end
                end
            end
            default: begin
                n_state = ST_CMD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_kind <= ld_kind;
            r_byte <= ld_byte;
            r_end <= ld_end;
            r_last <= ld_last;
        end
        r_cnt <= n_cnt;
        r_idx <= n_idx;
        r_msg <= n_msg;
        r_sec_data <= n_sec_data;
        r_sec_byte <= n_sec_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CMD;
            r_type_len <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_type_len <= n_type_len;
            if (ld) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_kind = r_kind;
    assign o_out_byte = r_byte;
    assign o_event_end = r_end;
    assign o_out_last = r_last;

endmodule
`default_nettype wire

// ===== hdl/sse_event_stream_parser.sv =====
// A data or error word is written into the command queue at the edge that accepts its
// input word and then loaded into the output register; a dispatch passes a fetch state
// and then loads one type word per stored type byte, or the default message name.
// Input is taken at one word per cycle while the command queue is not full.
// The four-entry command queue between front and back end sets how long input can run ahead.
// Reset is synchronous and active low; the type store holds no reset value.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event stream parser top level
// Parses a server-sent-events byte stream into data, event type and error words.
// ----------------------------------------------------------------------------
module sse_event_stream_parser #(
    parameter int TYPE_MAX = ssep_pkg::TYPE_MAX_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [ssep_pkg::LINE_W-1:0] i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [7:0]                  i_in_byte,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [1:0]                       o_out_kind,
    output logic [7:0]                       o_out_byte,
    output logic                             o_event_end,
    output logic                             o_out_last
);

    logic [ssep_pkg::LINE_W-1:0] r_max_len;
    logic                        accept;
    logic                        push, pop, full, empty;
    ssep_pkg::t_cmd              cmd, head;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall = full;
    assign accept = i_in_valid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= ssep_pkg::MAX_LINE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_len <= i_cfg_data;
        end
    end

    ssep_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte    (i_in_byte),
        .i_max_len (r_max_len),
        .o_push    (push),
        .o_cmd     (cmd)
    );

    ssep_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    ssep_back #(
        .TYPE_MAX (TYPE_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_kind  (o_out_kind),
        .o_out_byte  (o_out_byte),
        .o_event_end (o_event_end),
        .o_out_last  (o_out_last)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event stream parser testbench
// Streams data, event, blank and malformed lines through the parser. Both
// sides stall at random. Every result word is checked against a line model
// of the parser that this file keeps. The line limit is moved through
// several values, down to zero at the end.
// ----------------------------------------------------------------------------
module tb;
    import ssep_pkg::*;

    localparam int TYPE_CAP = TYPE_MAX_DEF;
    localparam int TYPE_AW = $clog2(TYPE_CAP);
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [55:0] EVENT_TAG = "event: ";
    localparam logic [47:0] DATA_TAG = "data: ";
    localparam logic [55:0] DEFAULT_TYPE = "message";

    typedef enum logic [2:0] {
        AT_START,
        IN_EVENT_TAG,
        IN_DATA_TAG,
        IN_EVENT,
        IN_DATA,
        IN_SKIP
    } line_state_e;

    typedef enum int {
        LINE_DATA,
        LINE_EVENT,
        LINE_BLANK,
        LINE_BROKEN,
        LINE_NOISE
    } line_kind_e;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       ev_end;
        logic       last;
    } word_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic [LINE_W-1:0] i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic [7:0]        i_in_byte = 8'd0;
    logic              i_out_stall = 1'b0;
    wire               o_cfg_ready;
    wire               o_in_stall;
    wire               o_out_valid;
    wire [1:0]         o_out_kind;
    wire [7:0]         o_out_byte;
    wire               o_event_end;
    wire               o_out_last;

    sse_event_stream_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_kind  (o_out_kind),
        .o_out_byte  (o_out_byte),
        .o_event_end (o_event_end),
        .o_out_last  (o_out_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    logic [7:0]  stream_q[$];
    word_t       expected_q[$];
    word_t       fresh[$];

    line_state_e mode = AT_START;
    int unsigned tag_pos = 0;
    int unsigned line_len = 0;
    int unsigned line_limit = 32'(MAX_LINE_RESET);
    bit          cr_held = 1'b0;
    bit          have_data = 1'b0;
    bit          stopped = 1'b0;
    logic [7:0]  type_buf[TYPE_CAP];
    int unsigned type_len = 0;

    int unsigned queued = 0;
    int unsigned n_bytes = 0;
    int unsigned n_data = 0;
    int unsigned n_type = 0;
    int unsigned n_error = 0;
    int unsigned n_errors = 0;
    int unsigned n_in_stalls = 0;
    int unsigned lo_limit = 32'(MAX_LINE_RESET);
    int unsigned hi_limit = 32'(MAX_LINE_RESET);

    int in_wait = 0;
    int in_calm = 0;
    int out_wait = 0;
    int out_calm = 0;
    int hold_left = 0;
    bit hold_toggle = 1'b0;
    bit hold_seen = 1'b0;
    bit rush = 1'b0;

    function automatic int pick_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 18)) : 0;
    endfunction

    function automatic logic [7:0] tag_char(input bit for_event, input int unsigned k);
        if (for_event) begin
            return EVENT_TAG[55 - 8 * k -: 8];
        end
        return DATA_TAG[47 - 8 * k -: 8];
    endfunction

    function automatic void note(input logic [1:0] kind, input logic [7:0] value,
                                 input logic ev_end);
        fresh.push_back('{kind, value, ev_end, 1'b0});
    endfunction

    function automatic void line_content(input logic [7:0] b);
        if (mode == IN_DATA) begin
            note(KIND_DATA, b, 1'b0);
            have_data = 1'b1;
        end else if (mode == IN_EVENT && type_len < TYPE_CAP) begin
            type_buf[type_len[TYPE_AW-1:0]] = b;
            type_len++;
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        int unsigned i;
        fresh.delete();
        if (stopped) begin
            return;
        end
        if (line_len + 1 > line_limit) begin
            stopped = 1'b1;
            note(KIND_ERROR, 8'd0, 1'b0);
        end else begin
            line_len++;
            if (b == CH_LF) begin
                if (mode == AT_START) begin
                    if (have_data && type_len == 0) begin
                        for (i = 0; i < 7; i++) begin
                            note(KIND_TYPE, DEFAULT_TYPE[55 - 8 * i -: 8], i == 6);
                        end
                    end else if (have_data) begin
                        for (i = 0; i < type_len; i++) begin
                            note(KIND_TYPE, type_buf[i[TYPE_AW-1:0]], i + 1 == type_len);
                        end
                    end
                    type_len = 0;
                    have_data = 1'b0;
                end
                mode = AT_START;
                tag_pos = 0;
                line_len = 0;
                cr_held = 1'b0;
            end else begin
                if (cr_held) begin
                    cr_held = 1'b0;
                    if (mode == AT_START) begin
                        mode = IN_SKIP;
                    end else begin
                        line_content(CH_CR);
                    end
                end
                case (mode)
                    AT_START: begin
                        if (b == CH_E) begin
                            mode = IN_EVENT_TAG;
                            tag_pos = 1;
                        end else if (b == CH_D) begin
                            mode = IN_DATA_TAG;
                            tag_pos = 1;
                        end else if (b == CH_CR) begin
                            cr_held = 1'b1;
                        end else begin
                            mode = IN_SKIP;
                        end
                    end
                    IN_EVENT_TAG: begin
                        if (b == tag_char(1'b1, tag_pos)) begin
                            tag_pos++;
                            if (tag_pos == 7) begin
                                mode = IN_EVENT;
                                type_len = 0;
                            end
                        end else begin
                            mode = IN_SKIP;
                        end
                    end
                    IN_DATA_TAG: begin
                        if (b == tag_char(1'b0, tag_pos)) begin
                            tag_pos++;
                            if (tag_pos == 6) begin
                                mode = IN_DATA;
                                if (have_data) begin
                                    note(KIND_DATA, CH_LF, 1'b0);
                                end
                            end
                        end else begin
                            mode = IN_SKIP;
                        end
                    end
                    IN_EVENT, IN_DATA: begin
                        if (b == CH_CR) begin
                            cr_held = 1'b1;
                        end else begin
                            line_content(b);
                        end
                    end
                    default: begin
                        mode = IN_SKIP;
                    end
                endcase
            end
        end
        if (fresh.size() > 0) begin
            fresh[fresh.size() - 1].last = 1'b1;
        end
        foreach (fresh[k]) begin
            expected_q.push_back(fresh[k]);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (in_wait > 0) begin
                in_wait--;
                i_in_valid <= 1'b0;
            end else if (stream_q.size() > 0) begin
                i_in_byte <= stream_q.pop_front();
                i_in_valid <= 1'b1;
                in_wait = rush ? 0 : pick_wait(in_calm);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        word_t want;
        logic  stall_next;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                parse_byte(i_in_byte);
                n_bytes++;
            end
            if (i_in_valid && o_in_stall) begin
                n_in_stalls++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result word: out_kind %0d, out_byte 0x%02h",
                           o_out_kind, o_out_byte);
                    n_errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (o_out_kind !== want.kind) begin
                        $error("out_kind: expected %0d, actual %0d", want.kind, o_out_kind);
                        n_errors++;
                    end
                    if (o_out_byte !== want.value) begin
                        $error("out_byte: expected 0x%02h, actual 0x%02h",
                               want.value, o_out_byte);
                        n_errors++;
                    end
                    if (o_event_end !== want.ev_end) begin
                        $error("event_end: expected %0d, actual %0d", want.ev_end, o_event_end);
                        n_errors++;
                    end
                    if (o_out_last !== want.last) begin
                        $error("out_last: expected %0d, actual %0d", want.last, o_out_last);
                        n_errors++;
                    end
                    case (want.kind)
                        KIND_DATA: n_data++;
                        KIND_TYPE: n_type++;
                        default: n_error++;
                    endcase
                end
                out_wait = pick_wait(out_calm);
            end
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (out_wait > 0) begin
                out_wait--;
                stall_next = 1'b1;
            end else begin
                stall_next = 1'b0;
            end
            i_out_stall <= stall_next;
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic put(input logic [7:0] b);
        stream_q.push_back(b);
        queued++;
    endtask

    task automatic put_tag(input bit for_event, input int unsigned upto);
        for (int unsigned k = 0; k < upto; k++) begin
            put(tag_char(for_event, k));
        end
    endtask

    task automatic put_body(input int unsigned n);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_LF || $urandom_range(0, 9) == 0) begin
                b = CH_CR;
            end
            put(b);
        end
    endtask

    task automatic put_end();
        if ($urandom_range(0, 2) == 0) begin
            put(CH_CR);
        end
        put(CH_LF);
    endtask

    task automatic put_line();
        int unsigned roll;
        line_kind_e  kind;
        bit          for_event;
        roll = $urandom_range(0, 99);
        if (roll < 40) kind = LINE_DATA;
        else if (roll < 55) kind = LINE_EVENT;
        else if (roll < 75) kind = LINE_BLANK;
        else if (roll < 90) kind = LINE_BROKEN;
        else kind = LINE_NOISE;
        case (kind)
            LINE_DATA: begin
                put_tag(1'b0, 6);
                put_body($urandom_range(0, 12));
            end
            LINE_EVENT: begin
                put_tag(1'b1, 7);
                put_body(($urandom_range(0, 9) == 0) ? $urandom_range(30, 40)
                                                     : $urandom_range(0, 8));
            end
            LINE_BROKEN: begin
                for_event = 1'($urandom_range(0, 1));
                put_tag(for_event, $urandom_range(1, for_event ? 6 : 5));
                put_body($urandom_range(0, 4));
            end
            LINE_NOISE: begin
                put_body($urandom_range(1, 10));
            end
            default: begin
            end
        endcase
        put_end();
    endtask

    task automatic add_lines(input int unsigned budget);
        int unsigned goal;
        goal = queued + budget;
        while (queued < goal) begin
            put_line();
        end
    endtask

    task automatic settle();
        do begin
            @(posedge i_clk);
        end while (stream_q.size() != 0 || i_in_valid || expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_line_limit(input logic [LINE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        line_limit = 32'(value);
        if (line_limit < lo_limit) lo_limit = line_limit;
        if (line_limit > hi_limit) hi_limit = line_limit;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_line_limit(24'hFFFFFF);
        put_tag(1'b0, 6);
        put(8'h00);
        put(8'hFF);
        put(CH_CR);
        put(CH_LF);
        put(CH_E);
        put(CH_CR);
        put(CH_LF);
        put_tag(1'b0, 6);
        put(CH_CR);
        put("x");
        put(CH_LF);
        put(CH_CR);
        put(CH_LF);
        put(CH_CR);
        put("q");
        put(CH_LF);
        add_lines(50);
        settle();

        set_line_limit(LINE_W'($urandom_range(64, 4096)));
        add_lines(40);
        settle();

        // The receiver holds off while the sender keeps pushing data lines.
        set_line_limit(MAX_LINE_RESET);
        rush <= 1'b1;
        hold_toggle <= ~hold_toggle;
        repeat (5) begin
            put_tag(1'b0, 6);
            put_body(8);
            put(CH_LF);
        end
        put(CH_LF);
        put_tag(1'b0, 6);
        put("z");
        put(CH_LF);
        settle();
        rush <= 1'b0;

        // Only line feeds fit under a limit of one; the first one dispatches.
        set_line_limit(24'd1);
        repeat (4) put(CH_LF);
        settle();

        // Every line here but the blank one fills the limit exactly.
        set_line_limit(24'd12);
        repeat (3) begin
            put_tag(1'b0, 6);
            put_body(5);
            put(CH_LF);
            put_tag(1'b1, 7);
            put_body(4);
            put(CH_LF);
            put_tag(1'b0, 6);
            put_body(4);
            put(CH_CR);
            put(CH_LF);
            put(CH_LF);
        end
        settle();

        set_line_limit(24'd0);
        repeat (4) put(8'($urandom_range(0, 255)));
        settle();

        if (expected_q.size() != 0) begin
            $error("%0d result words never arrived", expected_q.size());
            n_errors++;
        end
        $display("Summary: %0d stream bytes parsed into %0d data, %0d type and %0d error words.",
                 n_bytes, n_data, n_type, n_error);
        $display("Summary: line limits %0d to %0d, receiver hold of %0d cycles, %0d stalled offers.",
                 lo_limit, hi_limit, HOLD_CYCLES, n_in_stalls);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sse_event_stream_parser.f =====
hdl/ssep_pkg.sv
hdl/ssep_front.sv
hdl/ssep_queue.sv
hdl/ssep_back.sv
hdl/sse_event_stream_parser.sv
tb/sv/tb.sv
